### rtl/iap_pkg.sv
// Shared constants, widths and structs of the intercept aim point block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package iap_pkg;

  // Fraction bits of the Q format; they cancel in the solution.
  localparam int FRAC_BITS = 16;

  localparam int SPEED_W    = 31;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [SPEED_W-1:0]   SPEED_RESET    = 31'(1) << FRAC_BITS;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPEED  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 8'd1;
  localparam logic                 MODE_BALLISTIC = 1'b1;

  localparam int QM_W     = 64;
  localparam int C_W      = 67;
  localparam int AM_W     = 64;
  localparam int DISC_W   = 128;
  localparam int ROOT_W   = 64;
  localparam int SQ_REM_W = 67;
  localparam int NUM_W    = 67;
  localparam int DEN_W    = 65;
  localparam int PROD_W   = 99;
  localparam int QB       = 34;
  localparam int OFF_W    = 35;

  localparam logic [OFF_W-1:0] OFF_CLAMP = 35'h2_0000_0000;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // One classified request handed from front to back.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [QM_W-1:0]    qm;
    logic               qneg;
    logic [C_W-1:0]     c;
    logic [AM_W-1:0]    am;
    logic               apos;
    logic               lin;
    logic               skip;
  } iap_job_t;

  // Sideband that travels with the two divider lanes.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               negx;
    logic               negy;
    logic               bigx;
    logic               bigy;
    logic               skip;
  } iap_dside_t;

endpackage
`default_nettype wire

### rtl/iap_ifs.sv
// Valid/ready channel interfaces: request input, result output, config writes.
// Depends on iap_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
interface iap_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_vx;
  logic signed [31:0] target_vy;
  logic signed [31:0] shooter_x;
  logic signed [31:0] shooter_y;
  modport source (output valid, target_x, target_y, target_vx, target_vy,
                  shooter_x, shooter_y, input ready);
  modport sink (input valid, target_x, target_y, target_vx, target_vy,
                shooter_x, shooter_y, output ready);
endinterface

interface iap_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] aim_x;
  logic signed [31:0] aim_y;
  logic               solved;
  modport source (output valid, aim_x, aim_y, solved, input ready);
  modport sink (input valid, aim_x, aim_y, solved, output ready);
endinterface

interface iap_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [iap_pkg::CFG_IDX_W-1:0]  index;
  logic [iap_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/intercept_aim_point_2d_top.sv
// Top level of the intercept aim point block: config registers, front end,
// request queue and back end. Depends on iap_pkg, iap_ifs, iap_front,
// iap_fifo and iap_back.
//
// Usage: in_ch carries one request (target position, target velocity,
// shooter position, all signed Q16.16); out_ch returns one result per
// request, in order: the aim point and a solved flag. cfg_ch writes
// projectile_speed (index 0) and projectile_mode (index 1); it is always
// ready, and other indexes are ignored. Write it only while no request
// is in flight.
// Throughput: one request per cycle while out_ch is not stalled. The 64-stage square
// root and the 34-stage divider make up most of the pipeline.
// Reset: clears all valid bits and the queue; speed returns to 1.0 and
// mode to direct fire.
// Stall: when out_ch.ready is low the back end holds, the 4-entry queue
// fills, and in_ch.ready drops once the front end is backed up.
`timescale 1ns / 1ps
`default_nettype none
module intercept_aim_point_2d_top (
  input  logic       clk,
  input  logic       rst_n,
  iap_in_if.sink     in_ch,
  iap_out_if.source  out_ch,
  iap_cfg_if.sink    cfg_ch
);

  logic [iap_pkg::SPEED_W-1:0] speed_r;
  logic                        mode_r;

  logic              f_valid, f_ready;
  iap_pkg::iap_job_t f_job;
  logic              q_valid, q_ready;
  iap_pkg::iap_job_t q_job;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= iap_pkg::SPEED_RESET;
      mode_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        iap_pkg::CFG_IDX_SPEED: speed_r <= cfg_ch.data[iap_pkg::SPEED_W-1:0];
        iap_pkg::CFG_IDX_MODE:  mode_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  iap_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .speed     (speed_r),
    .mode      (mode_r),
    .job_valid (f_valid),
    .job       (f_job),
    .job_ready (f_ready)
  );

  iap_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_data  (f_job),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_job),
    .pop_ready  (q_ready)
  );

  iap_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (q_job),
    .job_ready (q_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

### rtl/iap_front.sv
// Front end: accepts requests, forms dot products and norms, classifies.
// Depends on iap_pkg and iap_in_if.
`timescale 1ns / 1ps
`default_nettype none
module iap_front (
  input  logic                           clk,
  input  logic                           rst_n,
  iap_in_if.sink                         in_ch,
  input  logic [iap_pkg::SPEED_W-1:0]    speed,
  input  logic                           mode,
  output logic                           job_valid,
  output iap_pkg::iap_job_t              job,
  input  logic                           job_ready
);

  logic adv;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  logic signed [31:0] s1_px_r, s1_py_r, s1_dx_r, s1_dy_r;
  logic signed [32:0] s1_wx_r, s1_wy_r;
  logic               s1_skip_r;

  logic signed [31:0] s2_px_r, s2_py_r, s2_dx_r, s2_dy_r;
  logic               s2_skip_r;
  logic signed [64:0] s2_pxd_r, s2_pyd_r;
  logic signed [65:0] s2_cxx_r, s2_cyy_r;
  logic [63:0]        s2_vxx_r, s2_vyy_r;
  logic [61:0]        s2_ss_r;

  logic signed [31:0] s3_px_r, s3_py_r, s3_dx_r, s3_dy_r;
  logic               s3_skip_r;
  logic signed [65:0] s3_q_r;
  logic signed [66:0] s3_c_r;
  logic [63:0]        s3_vv_r;
  logic [61:0]        s3_ss_r;

  iap_pkg::iap_job_t  job_r, job_nxt;
  logic signed [65:0] q_abs;
  logic [63:0]        ss_ext;

  // Stall the whole pipe together when the queue is full.
  assign adv         = !s4_v_r || job_ready;
  assign in_ch.ready = adv;
  assign job_valid   = s4_v_r;
  assign job         = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r   <= in_ch.target_x;
      s1_py_r   <= in_ch.target_y;
      s1_dx_r   <= in_ch.target_vx;
      s1_dy_r   <= in_ch.target_vy;
      s1_wx_r   <= 33'(in_ch.shooter_x) - 33'(in_ch.target_x);
      s1_wy_r   <= 33'(in_ch.shooter_y) - 33'(in_ch.target_y);
      s1_skip_r <= (mode == iap_pkg::MODE_BALLISTIC) ||
                   (in_ch.target_vx == '0 && in_ch.target_vy == '0);

      s2_px_r   <= s1_px_r;
      s2_py_r   <= s1_py_r;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_skip_r <= s1_skip_r;
      s2_pxd_r  <= 65'(s1_wx_r) * 65'(s1_dx_r);
      s2_pyd_r  <= 65'(s1_wy_r) * 65'(s1_dy_r);
      s2_cxx_r  <= 66'(s1_wx_r) * 66'(s1_wx_r);
      s2_cyy_r  <= 66'(s1_wy_r) * 66'(s1_wy_r);
      s2_vxx_r  <= 64'(s1_dx_r) * 64'(s1_dx_r);
      s2_vyy_r  <= 64'(s1_dy_r) * 64'(s1_dy_r);
      s2_ss_r   <= 62'(speed) * 62'(speed);

      s3_px_r   <= s2_px_r;
      s3_py_r   <= s2_py_r;
      s3_dx_r   <= s2_dx_r;
      s3_dy_r   <= s2_dy_r;
      s3_skip_r <= s2_skip_r;
      s3_q_r    <= 66'(s2_pxd_r) + 66'(s2_pyd_r);
      s3_c_r    <= 67'(s2_cxx_r) + 67'(s2_cyy_r);
      s3_vv_r   <= s2_vxx_r + s2_vyy_r;
      s3_ss_r   <= s2_ss_r;

      job_r     <= job_nxt;
    end
  end

  always_comb begin
    q_abs          = s3_q_r[65] ? -s3_q_r : s3_q_r;
    ss_ext         = {2'b00, s3_ss_r};
    job_nxt.px     = s3_px_r;
    job_nxt.py     = s3_py_r;
    job_nxt.dx     = s3_dx_r;
    job_nxt.dy     = s3_dy_r;
    job_nxt.qm     = q_abs[63:0];
    job_nxt.qneg   = s3_q_r[65];
    job_nxt.c      = s3_c_r;
    job_nxt.apos   = s3_vv_r > ss_ext;
    job_nxt.lin    = s3_vv_r == ss_ext;
    job_nxt.am     = (s3_vv_r > ss_ext) ? s3_vv_r - ss_ext : ss_ext - s3_vv_r;
    job_nxt.skip   = s3_skip_r;
  end

endmodule
`default_nettype wire

### rtl/iap_fifo.sv
// Short request queue between front and back end.
// Depends on iap_pkg for the request struct and depth.
`timescale 1ns / 1ps
`default_nettype none
module iap_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  iap_pkg::iap_job_t push_data,
  output logic              push_ready,
  output logic              pop_valid,
  output iap_pkg::iap_job_t pop_data,
  input  logic              pop_ready
);

  iap_pkg::iap_job_t             mem_r [iap_pkg::FIFO_DEPTH];
  logic [iap_pkg::FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [iap_pkg::FIFO_AW:0]     count_r;
  logic                          push, pop;

  assign push_ready = count_r != (iap_pkg::FIFO_AW+1)'(iap_pkg::FIFO_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

### rtl/iap_sqrt.sv
// Pipelined integer square root, one result bit per stage, request rides along.
// Depends on iap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iap_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [iap_pkg::DISC_W-1:0]   in_x,
  input  iap_pkg::iap_job_t            in_job,
  output logic                         out_valid,
  output logic [iap_pkg::ROOT_W-1:0]   out_root,
  output iap_pkg::iap_job_t            out_job
);

  localparam int N = iap_pkg::ROOT_W;

  logic                           v_r    [N];
  logic [iap_pkg::DISC_W-1:0]     x_r    [N];
  logic [iap_pkg::SQ_REM_W-1:0]   rem_r  [N];
  logic [iap_pkg::ROOT_W-1:0]     root_r [N];
  iap_pkg::iap_job_t              job_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                         pv;
    logic [iap_pkg::DISC_W-1:0]   px;
    logic [iap_pkg::SQ_REM_W-1:0] prem, rem_t, trial;
    logic [iap_pkg::ROOT_W-1:0]   proot;
    iap_pkg::iap_job_t            pjob;
    logic                         ge;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign px    = in_x;
      assign prem  = '0;
      assign proot = '0;
      assign pjob  = in_job;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign px    = x_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign pjob  = job_r[k-1];
    end

    // Bring in the next two radicand bits and try root*4+1.
    assign rem_t = {prem[iap_pkg::SQ_REM_W-3:0], px[iap_pkg::DISC_W-1 -: 2]};
    assign trial = {1'b0, proot, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n)  v_r[k] <= 1'b0;
      else if (en) v_r[k] <= pv;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= px << 2;
        rem_r[k]  <= ge ? rem_t - trial : rem_t;
        root_r[k] <= {proot[iap_pkg::ROOT_W-2:0], ge};
        job_r[k]  <= pjob;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_job   = job_r[N-1];

endmodule
`default_nettype wire

### rtl/iap_div.sv
// Two-lane pipelined restoring divider for the offsets along x and y.
// One quotient bit per stage; lanes share the divisor. Depends on iap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iap_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [iap_pkg::PROD_W-1:0]  in_remx,
  input  logic [iap_pkg::PROD_W-1:0]  in_remy,
  input  logic [iap_pkg::DEN_W-1:0]   in_den,
  input  iap_pkg::iap_dside_t         in_side,
  output logic                        out_valid,
  output logic [iap_pkg::QB-1:0]      out_qx,
  output logic [iap_pkg::QB-1:0]      out_qy,
  output iap_pkg::iap_dside_t         out_side
);

  localparam int N = iap_pkg::QB;

  logic                         v_r    [N];
  logic [iap_pkg::PROD_W-1:0]   rx_r   [N];
  logic [iap_pkg::PROD_W-1:0]   ry_r   [N];
  logic [iap_pkg::DEN_W-1:0]    den_r  [N];
  logic [iap_pkg::QB-1:0]       qx_r   [N];
  logic [iap_pkg::QB-1:0]       qy_r   [N];
  iap_pkg::iap_dside_t          side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                       pv;
    logic [iap_pkg::PROD_W-1:0] prx, pry, dsh;
    logic [iap_pkg::DEN_W-1:0]  pden;
    logic [iap_pkg::QB-1:0]     pqx, pqy;
    iap_pkg::iap_dside_t        pside;
    logic                       gex, gey;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prx   = in_remx;
      assign pry   = in_remy;
      assign pden  = in_den;
      assign pqx   = '0;
      assign pqy   = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign prx   = rx_r[k-1];
      assign pry   = ry_r[k-1];
      assign pden  = den_r[k-1];
      assign pqx   = qx_r[k-1];
      assign pqy   = qy_r[k-1];
      assign pside = side_r[k-1];
    end

    assign dsh = iap_pkg::PROD_W'(pden) << (N - 1 - k);
    assign gex = prx >= dsh;
    assign gey = pry >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n)  v_r[k] <= 1'b0;
      else if (en) v_r[k] <= pv;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[k]   <= gex ? prx - dsh : prx;
        ry_r[k]   <= gey ? pry - dsh : pry;
        qx_r[k]   <= {pqx[iap_pkg::QB-2:0], gex};
        qy_r[k]   <= {pqy[iap_pkg::QB-2:0], gey};
        den_r[k]  <= pden;
        side_r[k] <= pside;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_qx    = qx_r[N-1];
  assign out_qy    = qy_r[N-1];
  assign out_side  = side_r[N-1];

endmodule
`default_nettype wire

### rtl/iap_back.sv
// Back end: discriminant, square root, root selection, lead offsets, output.
// Depends on iap_pkg, iap_sqrt, iap_div and iap_out_if.
`timescale 1ns / 1ps
`default_nettype none
module iap_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  iap_pkg::iap_job_t job,
  output logic              job_ready,
  iap_out_if.source         out_ch
);

  logic adv;

  // Discriminant partial products.
  logic              b1_v_r;
  iap_pkg::iap_job_t b1_job_r, b1_job_nxt;
  logic [63:0]       b1_pq00_r, b1_pq01_r, b1_pq11_r;
  logic [63:0]       b1_pc00_r, b1_pc01_r, b1_pc10_r, b1_pc11_r;
  logic [34:0]       b1_pc20_r, b1_pc21_r;

  logic              b2_v_r;
  iap_pkg::iap_job_t b2_job_r;
  logic [127:0]      b2_q2_r, b2_ac_r;

  logic              b3_v_r;
  iap_pkg::iap_job_t b3_job_r, b3_job_nxt;
  logic [127:0]      b3_disc_r;

  logic                        sq_v;
  logic [iap_pkg::ROOT_W-1:0]  sq_root;
  iap_pkg::iap_job_t           sq_job;

  // Root selection.
  logic signed [65:0]         qs, rs, ns;
  logic [65:0]                nabs;
  logic [iap_pkg::NUM_W-1:0]  num_nxt;
  logic [iap_pkg::DEN_W-1:0]  den_nxt;
  logic                       tneg;
  logic [31:0]                dxm_nxt, dym_nxt;

  logic                       b4_v_r;
  logic [iap_pkg::NUM_W-1:0]  b4_num_r;
  logic [iap_pkg::DEN_W-1:0]  b4_den_r;
  logic [31:0]                b4_dxm_r, b4_dym_r;
  iap_pkg::iap_dside_t        b4_side_r;

  logic                       b5_v_r;
  logic [63:0]                b5_nx0_r, b5_nx1_r, b5_ny0_r, b5_ny1_r;
  logic [34:0]                b5_nx2_r, b5_ny2_r;
  logic [iap_pkg::DEN_W-1:0]  b5_den_r;
  iap_pkg::iap_dside_t        b5_side_r;

  logic                       b6_v_r;
  logic [iap_pkg::PROD_W-1:0] b6_prodx_r, b6_prody_r;
  logic [iap_pkg::DEN_W-1:0]  b6_den_r;
  iap_pkg::iap_dside_t        b6_side_r;

  logic                       b7_v_r;
  logic [iap_pkg::PROD_W-1:0] b7_remx_r, b7_remy_r;
  logic [iap_pkg::DEN_W-1:0]  b7_den_r;
  iap_pkg::iap_dside_t        b7_side_r, b7_side_nxt;
  logic [iap_pkg::PROD_W-1:0] den_top;

  logic                       dv_v;
  logic [iap_pkg::QB-1:0]     dv_qx, dv_qy;
  iap_pkg::iap_dside_t        dv_side;

  logic [iap_pkg::OFF_W-1:0]  offx, offy;
  logic signed [34:0]         ax, ay;

  logic                       out_v_r;
  logic signed [31:0]         aim_x_r, aim_y_r, aim_x_nxt, aim_y_nxt;
  logic                       solved_r;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647)       r = 32'sh7fff_ffff;
    else if (v < -35'sd2147483648) r = 32'sh8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

  // Hold every stage while the output register is full and not taken.
  assign adv       = !out_v_r || out_ch.ready;
  assign job_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      b4_v_r  <= 1'b0;
      b5_v_r  <= 1'b0;
      b6_v_r  <= 1'b0;
      b7_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      b1_v_r  <= job_valid;
      b2_v_r  <= b1_v_r;
      b3_v_r  <= b2_v_r;
      b4_v_r  <= sq_v;
      b5_v_r  <= b4_v_r;
      b6_v_r  <= b5_v_r;
      b7_v_r  <= b6_v_r;
      out_v_r <= dv_v;
    end
  end

  always_comb begin
    b1_job_nxt      = job;
    b1_job_nxt.skip = job.skip || (job.lin && job.qm == '0);
    // Drop to the target position when the discriminant goes negative.
    b3_job_nxt      = b2_job_r;
    b3_job_nxt.skip = b2_job_r.skip ||
                      (!b2_job_r.lin && b2_job_r.apos && b2_q2_r < b2_ac_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_job_r      <= b1_job_nxt;
      b1_pq00_r     <= 64'(job.qm[31:0])  * 64'(job.qm[31:0]);
      b1_pq01_r     <= 64'(job.qm[31:0])  * 64'(job.qm[63:32]);
      b1_pq11_r     <= 64'(job.qm[63:32]) * 64'(job.qm[63:32]);
      b1_pc00_r     <= 64'(job.c[31:0])   * 64'(job.am[31:0]);
      b1_pc01_r     <= 64'(job.c[31:0])   * 64'(job.am[63:32]);
      b1_pc10_r     <= 64'(job.c[63:32])  * 64'(job.am[31:0]);
      b1_pc11_r     <= 64'(job.c[63:32])  * 64'(job.am[63:32]);
      b1_pc20_r     <= 35'(job.c[66:64])  * 35'(job.am[31:0]);
      b1_pc21_r     <= 35'(job.c[66:64])  * 35'(job.am[63:32]);

      b2_job_r <= b1_job_r;
      b2_q2_r  <= (128'(b1_pq11_r) << 64) + (128'(b1_pq01_r) << 33) + 128'(b1_pq00_r);
      b2_ac_r  <= 128'(b1_pc00_r) + (128'(b1_pc01_r) << 32) + (128'(b1_pc10_r) << 32)
                + (128'(b1_pc11_r) << 64) + (128'(b1_pc20_r) << 64)
                + (128'(b1_pc21_r) << 96);

      b3_job_r      <= b3_job_nxt;
      b3_disc_r     <= b2_job_r.apos ? b2_q2_r - b2_ac_r : b2_q2_r + b2_ac_r;
    end
  end

  iap_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (b3_v_r),
    .in_x      (b3_disc_r),
    .in_job    (b3_job_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_job   (sq_job)
  );

  always_comb begin
    qs   = sq_job.qneg ? -$signed(66'(sq_job.qm)) : $signed(66'(sq_job.qm));
    rs   = sq_job.apos ? $signed(66'(sq_root)) : -$signed(66'(sq_root));
    ns   = qs + rs;
    nabs = ns[65] ? 66'(-ns) : 66'(ns);
    if (sq_job.lin) begin
      num_nxt = sq_job.c;
      den_nxt = {sq_job.qm, 1'b0};
      tneg    = sq_job.qneg;
    end else begin
      num_nxt = iap_pkg::NUM_W'(nabs);
      den_nxt = {1'b0, sq_job.am};
      tneg    = ns[65] ^ !sq_job.apos;
    end
    dxm_nxt = sq_job.dx[31] ? 32'(-sq_job.dx) : 32'(sq_job.dx);
    dym_nxt = sq_job.dy[31] ? 32'(-sq_job.dy) : 32'(sq_job.dy);
  end

  assign den_top = iap_pkg::PROD_W'(b6_den_r) << iap_pkg::QB;

  // Quotients too wide for the divider clamp anyway.
  always_comb begin
    b7_side_nxt      = b6_side_r;
    b7_side_nxt.bigx = b6_prodx_r >= den_top;
    b7_side_nxt.bigy = b6_prody_r >= den_top;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b4_num_r       <= num_nxt;
      b4_den_r       <= den_nxt;
      b4_dxm_r       <= dxm_nxt;
      b4_dym_r       <= dym_nxt;
      b4_side_r.px   <= sq_job.px;
      b4_side_r.py   <= sq_job.py;
      b4_side_r.negx <= tneg ^ sq_job.dx[31];
      b4_side_r.negy <= tneg ^ sq_job.dy[31];
      b4_side_r.bigx <= 1'b0;
      b4_side_r.bigy <= 1'b0;
      b4_side_r.skip <= sq_job.skip;

      b5_nx0_r  <= 64'(b4_num_r[31:0])  * 64'(b4_dxm_r);
      b5_nx1_r  <= 64'(b4_num_r[63:32]) * 64'(b4_dxm_r);
      b5_nx2_r  <= 35'(b4_num_r[66:64]) * 35'(b4_dxm_r);
      b5_ny0_r  <= 64'(b4_num_r[31:0])  * 64'(b4_dym_r);
      b5_ny1_r  <= 64'(b4_num_r[63:32]) * 64'(b4_dym_r);
      b5_ny2_r  <= 35'(b4_num_r[66:64]) * 35'(b4_dym_r);
      b5_den_r  <= b4_den_r;
      b5_side_r <= b4_side_r;

      b6_prodx_r <= iap_pkg::PROD_W'(b5_nx0_r) + (iap_pkg::PROD_W'(b5_nx1_r) << 32)
                  + (iap_pkg::PROD_W'(b5_nx2_r) << 64);
      b6_prody_r <= iap_pkg::PROD_W'(b5_ny0_r) + (iap_pkg::PROD_W'(b5_ny1_r) << 32)
                  + (iap_pkg::PROD_W'(b5_ny2_r) << 64);
      b6_den_r   <= b5_den_r;
      b6_side_r  <= b5_side_r;

      b7_remx_r      <= b6_prodx_r;
      b7_remy_r      <= b6_prody_r;
      b7_den_r       <= b6_den_r;
      b7_side_r      <= b7_side_nxt;
    end
  end

  iap_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (b7_v_r),
    .in_remx   (b7_remx_r),
    .in_remy   (b7_remy_r),
    .in_den    (b7_den_r),
    .in_side   (b7_side_r),
    .out_valid (dv_v),
    .out_qx    (dv_qx),
    .out_qy    (dv_qy),
    .out_side  (dv_side)
  );

  always_comb begin
    offx = (dv_side.bigx || iap_pkg::OFF_W'(dv_qx) > iap_pkg::OFF_CLAMP) ?
           iap_pkg::OFF_CLAMP : iap_pkg::OFF_W'(dv_qx);
    offy = (dv_side.bigy || iap_pkg::OFF_W'(dv_qy) > iap_pkg::OFF_CLAMP) ?
           iap_pkg::OFF_CLAMP : iap_pkg::OFF_W'(dv_qy);
    ax   = dv_side.negx ? 35'(dv_side.px) - $signed(offx) : 35'(dv_side.px) + $signed(offx);
    ay   = dv_side.negy ? 35'(dv_side.py) - $signed(offy) : 35'(dv_side.py) + $signed(offy);
    aim_x_nxt = dv_side.skip ? dv_side.px : sat32(ax);
    aim_y_nxt = dv_side.skip ? dv_side.py : sat32(ay);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      aim_x_r  <= aim_x_nxt;
      aim_y_r  <= aim_y_nxt;
      solved_r <= !dv_side.skip;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.aim_x  = aim_x_r;
  assign out_ch.aim_y  = aim_y_r;
  assign out_ch.solved = solved_r;

endmodule
`default_nettype wire
